[sv/tgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, register indexes, gesture codes and widths of the touch
// gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

   // Field widths
   localparam int COORD_W  = 12;
   localparam int RAW_W    = 16;
   localparam int STATUS_W = 8;
   localparam int GEST_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CNT_W    = 3;
   localparam int EMPTY_W  = 2;

   // Divider: dividend is raw * display size, divisor a sensor resolution
   localparam int DVD_W         = RAW_W + COORD_W;
   localparam int DSR_W         = RAW_W;
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS     = DVD_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

   // Default policy counts
   localparam int DEBOUNCE_POLLS_DEF = 4;
   localparam int RELEASE_POLLS_DEF  = 2;
   localparam int ERROR_LIMIT_DEF    = 5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_X_RES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_Y_RES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_HEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_MIN_DY = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_MAX_DX = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_MAX_MOVE = 3'd7;

   // Gesture codes
   localparam logic [GEST_W-1:0] GEST_NONE       = 3'd0;
   localparam logic [GEST_W-1:0] GEST_SWIPE_UP   = 3'd1;
   localparam logic [GEST_W-1:0] GEST_SWIPE_DOWN = 3'd2;
   localparam logic [GEST_W-1:0] GEST_TAP_LEFT   = 3'd3;
   localparam logic [GEST_W-1:0] GEST_TAP_CENTRE = 3'd4;
   localparam logic [GEST_W-1:0] GEST_TAP_RIGHT  = 3'd5;

   // Status byte fields
   localparam int STATUS_READY_BIT = 7;
   localparam int STATUS_NPTS_W    = 4;

   // floor(n / 3) for 12-bit n as (n * THIRD_MUL) >> THIRD_SHIFT
   localparam logic [COORD_W-1:0] THIRD_MUL   = 12'd2731;
   localparam int                 THIRD_SHIFT = 13;

   typedef struct packed {
      logic                status_ok;
      logic [STATUS_W-1:0] status_byte;
      logic                point_ok;
      logic [RAW_W-1:0]    raw_x;
      logic [RAW_W-1:0]    raw_y;
   } req_type;

   typedef struct packed {
      logic [GEST_W-1:0]  gesture;
      logic               clear_status;
      logic               touching;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_sel_y;
      logic store_x;
      logic store_y;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } status_type;

endpackage

[sv/tgc_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_divider
// Restoring divider, two quotient bits per cycle; quotient left in the
// dividend register when done pulses.
// ----------------------------------------------------------------------------
module tgc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tgc_pkg::DVD_W-1:0]      dividend,
   input  logic [tgc_pkg::DSR_W-1:0]      divisor,
   output logic                           done,
   output logic [tgc_pkg::DVD_W-1:0]      quotient
);

   logic [tgc_pkg::DVD_W-1:0]     dvd_ff, dvd_in;
   logic [tgc_pkg::DSR_W-1:0]     rem_ff, rem_in;
   logic [tgc_pkg::DSR_W-1:0]     dsr_ff, dsr_in;
   logic [tgc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   // One radix-2^k step: shift in dividend bits, subtract where it fits
   function automatic logic [tgc_pkg::DSR_W+tgc_pkg::DVD_W-1:0] div_step(
      input logic [tgc_pkg::DSR_W-1:0] rem,
      input logic [tgc_pkg::DVD_W-1:0] dvd,
      input logic [tgc_pkg::DSR_W-1:0] dsr
   );
      logic [tgc_pkg::DSR_W:0]   r;
      logic [tgc_pkg::DSR_W-1:0] rm;
      logic [tgc_pkg::DVD_W-1:0] d;
      rm = rem;
      d  = dvd;
      for (int i = 0; i < tgc_pkg::DIV_RADIX_BITS; i++) begin
         r = {rm, d[tgc_pkg::DVD_W-1]};
         d = {d[tgc_pkg::DVD_W-2:0], 1'b0};
         if (r >= {1'b0, dsr}) begin
            r    = r - {1'b0, dsr};
            d[0] = 1'b1;
         end
         rm = r[tgc_pkg::DSR_W-1:0];
      end
      return {rm, d};
   endfunction

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         {rem_in, dvd_in} = div_step(rem_ff, dvd_ff, dsr_ff);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tgc_pkg::DIV_CNT_W'(tgc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[sv/tgc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_datapath
// Configuration registers, touch tracking state, scaling and clamping,
// gesture classification and the result register.
// ----------------------------------------------------------------------------
module tgc_datapath #(
   parameter int DEBOUNCE_POLLS = tgc_pkg::DEBOUNCE_POLLS_DEF,
   parameter int RELEASE_POLLS  = tgc_pkg::RELEASE_POLLS_DEF,
   parameter int ERROR_LIMIT    = tgc_pkg::ERROR_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tgc_pkg::req_type                  req_data,
   input  logic                              csr_we,
   input  logic [tgc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]    csr_data,
   input  tgc_pkg::cmd_type                  cmd,
   output tgc_pkg::status_type               status,
   output tgc_pkg::rsp_type                  rsp_data
);

   localparam int CW = tgc_pkg::COORD_W;

   // Configuration
   logic                      enable_ff;
   logic [tgc_pkg::RAW_W-1:0] sens_x_ff, sens_y_ff;
   logic [CW-1:0]             disp_w_ff, disp_h_ff;
   logic [CW-1:0]             swipe_min_dy_ff, swipe_max_dx_ff, tap_max_move_ff;

   // Tracking state
   logic                          was_touching_ff, was_touching_in;
   logic [CW-1:0]                 start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [CW-1:0]                 last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [tgc_pkg::EMPTY_W-1:0]   empty_ff, empty_in;
   logic [tgc_pkg::CNT_W-1:0]     debounce_ff, debounce_in;
   logic [tgc_pkg::CNT_W-1:0]     error_ff, error_in;
   logic                          touch_ff, touch_in;

   // Per-transaction registers
   tgc_pkg::req_type              cap_ff;
   logic [tgc_pkg::DVD_W-1:0]     quot_x_ff, quot_y_ff;
   tgc_pkg::rsp_type              rsp_ff;

   logic [CW-1:0]                 dw, dh;
   logic                          scale_live, scale_cap;
   logic [tgc_pkg::DVD_W-1:0]     div_dividend, div_quotient;
   logic [tgc_pkg::DSR_W-1:0]     div_divisor;
   logic                          div_done;
   logic [CW-1:0]                 pt_x, pt_y;
   logic [tgc_pkg::GEST_W-1:0]    gesture_in, class_gest;
   logic                          clear_in;
   logic [tgc_pkg::EMPTY_W-1:0]   empty_inc;
   logic [CW-1:0]                 adx, ady;
   logic [2*CW-1:0]               third_prod;
   logic [CW-1:0]                 third, two_thirds;

   // A display size of zero behaves as one
   assign dw = (disp_w_ff == '0) ? CW'(1) : disp_w_ff;
   assign dh = (disp_h_ff == '0) ? CW'(1) : disp_h_ff;

   function automatic logic scale_needed(
      input logic [tgc_pkg::RAW_W-1:0] sx,
      input logic [tgc_pkg::RAW_W-1:0] sy,
      input logic [CW-1:0]             w,
      input logic [CW-1:0]             h
   );
      return (sx != '0) && (sy != '0) &&
             ((sx != {4'b0, w}) || (sy != {4'b0, h}));
   endfunction

   // Clamp the full value to size - 1
   function automatic logic [CW-1:0] clamp_axis(
      input logic [tgc_pkg::DVD_W-1:0] v,
      input logic [CW-1:0]             size
   );
      return (v >= tgc_pkg::DVD_W'(size)) ? (size - 1'b1) : v[CW-1:0];
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         sens_x_ff       <= 16'd720;
         sens_y_ff       <= 16'd720;
         disp_w_ff       <= 12'd720;
         disp_h_ff       <= 12'd720;
         swipe_min_dy_ff <= 12'd80;
         swipe_max_dx_ff <= 12'd60;
         tap_max_move_ff <= 12'd20;
      end else if (csr_we) begin
         unique case (csr_index)
            tgc_pkg::CSR_ENABLE:       enable_ff       <= csr_data[0];
            tgc_pkg::CSR_SENSOR_X_RES: sens_x_ff       <= csr_data;
            tgc_pkg::CSR_SENSOR_Y_RES: sens_y_ff       <= csr_data;
            tgc_pkg::CSR_DISP_WIDTH:   disp_w_ff       <= csr_data[CW-1:0];
            tgc_pkg::CSR_DISP_HEIGHT:  disp_h_ff       <= csr_data[CW-1:0];
            tgc_pkg::CSR_SWIPE_MIN_DY: swipe_min_dy_ff <= csr_data[CW-1:0];
            tgc_pkg::CSR_SWIPE_MAX_DX: swipe_max_dx_ff <= csr_data[CW-1:0];
            tgc_pkg::CSR_TAP_MAX_MOVE: tap_max_move_ff <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // Division needed only when a good point gets scaled this poll
   assign scale_live = scale_needed(sens_x_ff, sens_y_ff, dw, dh);
   assign scale_cap  = scale_live;

   assign status.need_div = enable_ff && (debounce_ff == '0) &&
      (error_ff <= tgc_pkg::CNT_W'(ERROR_LIMIT)) && req_data.status_ok &&
      req_data.status_byte[tgc_pkg::STATUS_READY_BIT] &&
      (req_data.status_byte[tgc_pkg::STATUS_NPTS_W-1:0] != '0) &&
      req_data.point_ok && scale_live;
   assign status.div_done = div_done;

   assign div_dividend = cmd.div_sel_y ? (cap_ff.raw_y * dh) : (cap_ff.raw_x * dw);
   assign div_divisor  = cmd.div_sel_y ? sens_y_ff : sens_x_ff;

   tgc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) cap_ff    <= req_data;
      if (cmd.store_x) quot_x_ff <= div_quotient;
      if (cmd.store_y) quot_y_ff <= div_quotient;
   end

   assign pt_x = clamp_axis(scale_cap ? quot_x_ff : tgc_pkg::DVD_W'(cap_ff.raw_x), dw);
   assign pt_y = clamp_axis(scale_cap ? quot_y_ff : tgc_pkg::DVD_W'(cap_ff.raw_y), dh);

   // Classification on the tracked start and last points
   assign adx = (last_x_ff >= start_x_ff) ? (last_x_ff - start_x_ff)
                                          : (start_x_ff - last_x_ff);
   assign ady = (last_y_ff >= start_y_ff) ? (last_y_ff - start_y_ff)
                                          : (start_y_ff - last_y_ff);
   assign third_prod = dw * tgc_pkg::THIRD_MUL;
   assign third      = CW'(third_prod >> tgc_pkg::THIRD_SHIFT);
   assign two_thirds = {third[CW-2:0], 1'b0};

   always_comb begin
      if ((ady >= swipe_min_dy_ff) && (adx < swipe_max_dx_ff)) begin
         class_gest = (last_y_ff < start_y_ff) ? tgc_pkg::GEST_SWIPE_UP
                                               : tgc_pkg::GEST_SWIPE_DOWN;
      end else if ((adx < tap_max_move_ff) && (ady < tap_max_move_ff)) begin
         if (start_x_ff < third) begin
            class_gest = tgc_pkg::GEST_TAP_LEFT;
         end else if (start_x_ff > two_thirds) begin
            class_gest = tgc_pkg::GEST_TAP_RIGHT;
         end else begin
            class_gest = tgc_pkg::GEST_TAP_CENTRE;
         end
      end else begin
         class_gest = tgc_pkg::GEST_NONE;
      end
   end

   assign empty_inc = (empty_ff < 2'd3) ? (empty_ff + 1'b1) : empty_ff;

   // Poll update
   always_comb begin
      was_touching_in = was_touching_ff;
      start_x_in      = start_x_ff;
      start_y_in      = start_y_ff;
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;
      empty_in        = empty_ff;
      debounce_in     = debounce_ff;
      error_in        = error_ff;
      touch_in        = touch_ff;
      gesture_in      = tgc_pkg::GEST_NONE;
      clear_in        = 1'b0;
      if (!enable_ff) begin
         // hold everything
      end else if (debounce_ff != '0) begin
         debounce_in = debounce_ff - 1'b1;
      end else if (error_ff > tgc_pkg::CNT_W'(ERROR_LIMIT)) begin
         error_in = error_ff - 1'b1;
      end else if (!cap_ff.status_ok) begin
         if (error_ff != 3'd7) error_in = error_ff + 1'b1;
      end else begin
         error_in = '0;
         if (cap_ff.status_byte[tgc_pkg::STATUS_READY_BIT]) begin
            clear_in = 1'b1;
            if (cap_ff.status_byte[tgc_pkg::STATUS_NPTS_W-1:0] != '0) begin
               empty_in = '0;
               if (cap_ff.point_ok) begin
                  touch_in = 1'b1;
                  if (!was_touching_ff) begin
                     start_x_in      = pt_x;
                     start_y_in      = pt_y;
                     was_touching_in = 1'b1;
                  end
                  last_x_in = pt_x;
                  last_y_in = pt_y;
               end
            end else begin
               touch_in = 1'b0;
               if (was_touching_ff) begin
                  empty_in = empty_inc;
                  if (empty_inc >= tgc_pkg::EMPTY_W'(RELEASE_POLLS)) begin
                     was_touching_in = 1'b0;
                     empty_in        = '0;
                     gesture_in      = class_gest;
                     if (class_gest != tgc_pkg::GEST_NONE) begin
                        debounce_in = tgc_pkg::CNT_W'(DEBOUNCE_POLLS);
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_touching_ff <= 1'b0;
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         empty_ff        <= '0;
         debounce_ff     <= '0;
         error_ff        <= '0;
         touch_ff        <= 1'b0;
      end else if (cmd.commit) begin
         was_touching_ff <= was_touching_in;
         start_x_ff      <= start_x_in;
         start_y_ff      <= start_y_in;
         last_x_ff       <= last_x_in;
         last_y_ff       <= last_y_in;
         empty_ff        <= empty_in;
         debounce_ff     <= debounce_in;
         error_ff        <= error_in;
         touch_ff        <= touch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.gesture      <= gesture_in;
         rsp_ff.clear_status <= clear_in;
         rsp_ff.touching     <= touch_in;
         rsp_ff.pos_x        <= last_x_in;
         rsp_ff.pos_y        <= last_y_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[sv/tgc_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_controller
// Sequencer for one poll: capture, two divisions when scaling, commit into
// the result register.
// ----------------------------------------------------------------------------
module tgc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tgc_pkg::status_type status,
   output tgc_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_START_X = 3'd1;
   localparam logic [2:0] ST_WAIT_X  = 3'd2;
   localparam logic [2:0] ST_START_Y = 3'd3;
   localparam logic [2:0] ST_WAIT_Y  = 3'd4;
   localparam logic [2:0] ST_COMMIT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.need_div ? ST_START_X : ST_COMMIT;
            end
         end
         ST_START_X: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_X;
         end
         ST_WAIT_X: begin
            if (status.div_done) begin
               cmd.store_x = 1'b1;
               state_in    = ST_START_Y;
            end
         end
         ST_START_Y: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in      = ST_WAIT_Y;
         end
         ST_WAIT_Y: begin
            cmd.div_sel_y = 1'b1;
            if (status.div_done) begin
               cmd.store_y = 1'b1;
               state_in    = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/touch_gesture_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Turns polls of a touch controller into one result transaction each: the
// gesture seen on release (swipe up or down, tap left, centre or right), a
// flag to write the status register back to zero, the touch indication and
// the last display position. A poll whose point needs scaling runs two
// sequential divisions (x then y) on one shared radix-4 divider. Each
// division is started, steps through the dividend two bits at a time and
// has its quotient stored; such a poll is committed after the y quotient
// is stored. Every other poll goes from acceptance straight to the commit
// state. The commit waits while an earlier result has not yet been taken.
// One poll is worked on at a time. The next request is accepted as soon
// as the previous one has been committed into the output register, even
// while that result still waits to be taken. Configuration writes are
// always accepted and must only be issued while the block is idle.
// Coordinates are scaled as raw * display / sensor and clamped to the
// display size minus one. A zero sensor resolution, or both resolutions
// equal to the display, leaves coordinates unscaled.
// ----------------------------------------------------------------------------
module touch_gesture_classifier #(
   parameter int DEBOUNCE_POLLS = tgc_pkg::DEBOUNCE_POLLS_DEF,
   parameter int RELEASE_POLLS  = tgc_pkg::RELEASE_POLLS_DEF,
   parameter int ERROR_LIMIT    = tgc_pkg::ERROR_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Poll requests
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tgc_pkg::req_type                  req_data,
   // Results
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tgc_pkg::rsp_type                  rsp_data,
   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tgc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]    csr_data
);

   tgc_pkg::cmd_type    cmd;
   tgc_pkg::status_type status;

   // Register writes complete in the cycle they are offered
   assign csr_ready = 1'b1;

   // Sequencing of each poll transaction and the result handshake
   tgc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, tracking state, divider, classification and result register
   tgc_datapath #(
      .DEBOUNCE_POLLS (DEBOUNCE_POLLS),
      .RELEASE_POLLS  (RELEASE_POLLS),
      .ERROR_LIMIT    (ERROR_LIMIT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/tgc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
module tgc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tgc_pkg::rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.gesture <= tgc_pkg::GEST_TAP_RIGHT)
      else $error("gesture code out of range");

   // A gesture only comes from a released finger on a ready buffer
   a_gesture_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.gesture != tgc_pkg::GEST_NONE) |->
         !rsp_data.touching && rsp_data.clear_status)
      else $error("gesture without release");

   a_pos_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pos_x != 12'hFFF) && (rsp_data.pos_y != 12'hFFF))
      else $error("position beyond display clamp");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[dv/touch_gesture_classifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_tb
// Self-checking bench for the touch gesture classifier. A short table of
// directed polls comes first: disabled block, read errors and back-off, an
// empty frame, a swipe, a debounce window and a clamped tap. Random phases
// follow, each under its own register setting: mostly well-formed touch and
// release sequences, with error bursts and noise mixed in. A local model
// of the classifier predicts every result the table does not give, and
// each is checked field by field in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_tb;
   import tgc_pkg::*;

   localparam int SETTLE_CYCLES = 40;    // longer than a scaled poll takes
   localparam int STALL_LIMIT   = 4000;  // cycles with no transaction at all

   // Expected results must not be swamped by stray rows of a broken run
   localparam rsp_type RSP_QUIET   = '0;
   localparam rsp_type RSP_CLEARED = '{gesture: GEST_NONE, clear_status: 1'b1,
                                       touching: 1'b0, pos_x: '0, pos_y: '0};

   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] word;
      req_type               poll;
      bit                    typed;
      rsp_type               want;
   } stim_row_type;

   // -------------------------------------------------------------------------
   // Block ports: every input holds a known value from time zero
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   touch_gesture_classifier u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Local copy of the register file and the touch tracker
   // -------------------------------------------------------------------------
   logic               cfg_enable;
   logic [RAW_W-1:0]   cfg_sens_x, cfg_sens_y;
   logic [COORD_W-1:0] cfg_disp_w, cfg_disp_h;
   logic [COORD_W-1:0] cfg_swipe_dy, cfg_swipe_dx, cfg_tap_move;

   logic               was_down;      // finger seen since the last release
   logic [COORD_W-1:0] down_x, down_y;
   logic [COORD_W-1:0] cur_x, cur_y;
   logic [EMPTY_W-1:0] gap_frames;    // empty frames while down
   logic [CNT_W-1:0]   hold_off;      // debounce polls still to serve
   logic [CNT_W-1:0]   err_run;       // consecutive status read errors
   logic               contact;

   rsp_type pending_results [$];
   stim_row_type dir_rows [$];
   rsp_type oldest_result;

   int send_idle_pct = 21;
   int recv_idle_pct = 70;
   int polls_sent, results_checked, fail_count, settings_applied;
   int gesture_seen [8];
   int stall_cycles;

   // A display dimension of zero behaves as one
   function automatic int unsigned span(input logic [COORD_W-1:0] d);
      return (d == 0) ? 1 : d;
   endfunction

   // Zero sensor resolution, or both resolutions equal to the display: bypass
   function automatic bit scaling_on();
      return cfg_sens_x != 0 && cfg_sens_y != 0 &&
             (cfg_sens_x != span(cfg_disp_w) || cfg_sens_y != span(cfg_disp_h));
   endfunction

   // Scale first, clamp the full value afterwards
   function automatic logic [COORD_W-1:0] fit_axis(input logic [RAW_W-1:0] raw,
                                                   input int unsigned lim,
                                                   input logic [RAW_W-1:0] sens,
                                                   input bit scale);
      int unsigned r, s, v;
      r = raw;
      s = sens;
      v = scale ? (r * lim) / s : r;
      if (v >= lim) v = lim - 1;
      return v[COORD_W-1:0];
   endfunction

   // Advance the tracker by one poll and return the result it must produce
   function automatic rsp_type classify_poll(input req_type p);
      rsp_type            res;
      int unsigned        w, h, adx, ady, third;
      logic [COORD_W-1:0] px, py;
      logic [GEST_W-1:0]  g;
      logic               clr;
      bit                 scale;
      w   = span(cfg_disp_w);
      h   = span(cfg_disp_h);
      g   = GEST_NONE;
      clr = 1'b0;
      if (cfg_enable) begin
         if (hold_off != 0) begin
            hold_off = hold_off - 1'b1;
         end else if (err_run > ERROR_LIMIT_DEF) begin
            err_run = err_run - 1'b1;
         end else if (!p.status_ok) begin
            if (err_run < 7) err_run = err_run + 1'b1;
         end else begin
            err_run = '0;
            if (p.status_byte[STATUS_READY_BIT]) begin
               clr = 1'b1;
               if (p.status_byte[STATUS_NPTS_W-1:0] != 0) begin
                  gap_frames = '0;
                  if (p.point_ok) begin
                     scale = scaling_on();
                     px = fit_axis(p.raw_x, w, cfg_sens_x, scale);
                     py = fit_axis(p.raw_y, h, cfg_sens_y, scale);
                     contact = 1'b1;
                     if (!was_down) begin
                        down_x   = px;
                        down_y   = py;
                        was_down = 1'b1;
                     end
                     cur_x = px;
                     cur_y = py;
                  end
               end else begin
                  contact = 1'b0;
                  if (was_down) begin
                     if (gap_frames < 3) gap_frames = gap_frames + 1'b1;
                     if (gap_frames >= RELEASE_POLLS_DEF) begin
                        // Release confirmed: classify the travel
                        was_down   = 1'b0;
                        gap_frames = '0;
                        adx = (cur_x >= down_x) ? cur_x - down_x : down_x - cur_x;
                        ady = (cur_y >= down_y) ? cur_y - down_y : down_y - cur_y;
                        if (ady >= cfg_swipe_dy && adx < cfg_swipe_dx) begin
                           g = (cur_y < down_y) ? GEST_SWIPE_UP : GEST_SWIPE_DOWN;
                        end else if (adx < cfg_tap_move && ady < cfg_tap_move) begin
                           third = w / 3;
                           if (down_x < third) g = GEST_TAP_LEFT;
                           else if (down_x > third * 2) g = GEST_TAP_RIGHT;
                           else g = GEST_TAP_CENTRE;
                        end
                        if (g != GEST_NONE) hold_off = CNT_W'(DEBOUNCE_POLLS_DEF);
                     end
                  end
               end
            end
         end
      end
      res.gesture      = g;
      res.clear_status = clr;
      res.touching     = contact;
      res.pos_x        = cur_x;
      res.pos_y        = cur_y;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus builders
   // -------------------------------------------------------------------------
   function automatic req_type mk_poll(input bit ok, input logic [STATUS_W-1:0] st,
                                       input bit pok, input logic [RAW_W-1:0] x,
                                       input logic [RAW_W-1:0] y);
      req_type r;
      r.status_ok   = ok;
      r.status_byte = st;
      r.point_ok    = pok;
      r.raw_x       = x;
      r.raw_y       = y;
      return r;
   endfunction

   function automatic stim_row_type poll_row(input req_type p);
      stim_row_type row;
      row.kind  = ROW_POLL;
      row.idx   = '0;
      row.word  = '0;
      row.poll  = p;
      row.typed = 1'b0;
      row.want  = RSP_QUIET;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input req_type p, input rsp_type want);
      stim_row_type row;
      row       = poll_row(p);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] word);
      stim_row_type row;
      row      = poll_row('0);
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.word = word;
      return row;
   endfunction

   // Register words in index order
   function automatic logic [7:0][CSR_DATA_W-1:0] cfg_set(
         input logic [CSR_DATA_W-1:0] en, sx, sy, w, h, dy, dx, tap);
      logic [7:0][CSR_DATA_W-1:0] words;
      words[CSR_ENABLE]       = en;
      words[CSR_SENSOR_X_RES] = sx;
      words[CSR_SENSOR_Y_RES] = sy;
      words[CSR_DISP_WIDTH]   = w;
      words[CSR_DISP_HEIGHT]  = h;
      words[CSR_SWIPE_MIN_DY] = dy;
      words[CSR_SWIPE_MAX_DX] = dx;
      words[CSR_TAP_MAX_MOVE] = tap;
      return words;
   endfunction

   // 12-bit register value with random junk in the unused top bits
   function automatic logic [CSR_DATA_W-1:0] junk12(input int unsigned v);
      return {4'($urandom), v[COORD_W-1:0]};
   endfunction

   // Raw sensor value that lands roughly on display position d
   function automatic logic [RAW_W-1:0] to_raw(input int d, input logic [COORD_W-1:0] disp,
                                               input logic [RAW_W-1:0] sens);
      int v;
      if (d < 0) d = 0;
      v = scaling_on() ? (d * int'(sens)) / int'(span(disp)) : d;
      if (v > 65535) v = 65535;
      return v[RAW_W-1:0];
   endfunction

   // -------------------------------------------------------------------------
   // Channel drivers
   // -------------------------------------------------------------------------

   // Offer one poll transaction, hold it until taken, then predict its result
   task automatic send_poll(input req_type p, input bit typed, input rsp_type want);
      rsp_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      got = classify_poll(p);
      pending_results.push_back(typed ? want : got);
      polls_sent++;
   endtask

   // Leave csr_valid high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] word);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ENABLE:       cfg_enable   = word[0];
         CSR_SENSOR_X_RES: cfg_sens_x   = word;
         CSR_SENSOR_Y_RES: cfg_sens_y   = word;
         CSR_DISP_WIDTH:   cfg_disp_w   = word[COORD_W-1:0];
         CSR_DISP_HEIGHT:  cfg_disp_h   = word[COORD_W-1:0];
         CSR_SWIPE_MIN_DY: cfg_swipe_dy = word[COORD_W-1:0];
         CSR_SWIPE_MAX_DX: cfg_swipe_dx = word[COORD_W-1:0];
         CSR_TAP_MAX_MOVE: cfg_tap_move = word[COORD_W-1:0];
         default: ;
      endcase
   endtask

   // Stop offering polls and wait until the block has gone idle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One finger down, a short path, then release frames
   task automatic play_touch();
      int w, h, sx, sy, ex, ey, px, py, k, j, roll, drops;
      w  = span(cfg_disp_w);
      h  = span(cfg_disp_h);
      sx = $urandom_range(w - 1);
      sy = $urandom_range(h - 1);
      case ($urandom_range(2))
         0: begin
            // vertical travel past the swipe minimum, little sideways drift
            j  = $urandom_range(60);
            ey = ($urandom_range(1) == 1) ? sy + int'(cfg_swipe_dy) + j
                                          : sy - int'(cfg_swipe_dy) - j;
            j  = $urandom_range(cfg_swipe_dx);
            ex = sx + j - int'(cfg_swipe_dx) / 2;
         end
         1: begin
            j  = $urandom_range(cfg_tap_move);
            ex = sx + j - int'(cfg_tap_move) / 2;
            j  = $urandom_range(cfg_tap_move);
            ey = sy + j - int'(cfg_tap_move) / 2;
         end
         default: begin
            // overshoot the display now and then to exercise the clamp
            ex = $urandom_range(w + w / 8);
            ey = $urandom_range(h + h / 8);
         end
      endcase
      k = $urandom_range(6, 1);
      for (int i = 0; i < k; i++) begin
         px   = (k == 1) ? sx : sx + (ex - sx) * i / (k - 1);
         py   = (k == 1) ? sy : sy + (ey - sy) * i / (k - 1);
         roll = $urandom_range(99);
         if (roll < 5) begin
            send_poll(mk_poll(1'b0, 8'($urandom), 1'b1, 16'($urandom), 16'($urandom)),
                      1'b0, RSP_QUIET);
         end else begin
            send_poll(mk_poll(1'b1,
                              8'h80 | 8'($urandom_range(7) << 4) | 8'($urandom_range(15, 1)),
                              roll >= 12,
                              to_raw(px, cfg_disp_w, cfg_sens_x),
                              to_raw(py, cfg_disp_h, cfg_sens_y)),
                      1'b0, RSP_QUIET);
         end
      end
      // Mostly a clean release; sometimes one frame short, sometimes one extra
      roll  = $urandom_range(99);
      drops = (roll < 10) ? 1 : (roll < 20) ? 3 : 2;
      repeat (drops) begin
         send_poll(mk_poll(1'b1, 8'h80 | 8'($urandom_range(7) << 4), 1'($urandom),
                           16'($urandom), 16'($urandom)),
                   1'b0, RSP_QUIET);
      end
   endtask

   // Apply one register setting while idle, then stream random polls under it
   task automatic run_phase(input logic [7:0][CSR_DATA_W-1:0] words, input int n_items);
      int stop_at, pick, n;
      drain_block();
      for (int i = 0; i < 8; i++) write_reg(CSR_IDX_W'(i), words[i]);
      csr_valid <= 1'b0;
      settings_applied++;
      stop_at = polls_sent + n_items;
      while (polls_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            play_touch();
         end else if (pick < 82) begin
            // error burst, long enough at times to trigger the back-off
            n = $urandom_range(8, 1);
            repeat (n) begin
               send_poll(mk_poll(1'b0, 8'($urandom), 1'($urandom), 16'($urandom),
                                 16'($urandom)),
                         1'b0, RSP_QUIET);
            end
         end else begin
            send_poll(mk_poll(1'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
                              16'($urandom)),
                      1'b0, RSP_QUIET);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d actual %0d",
                  $time, name, want_v, got_v);
      end
   endtask

   // Randomise rsp_ready every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Take each result transaction and compare it with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         gesture_seen[rsp_data.gesture]++;
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t ns: result with no poll outstanding, expected none actual %h",
                     $time, rsp_data);
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("gesture", oldest_result.gesture, rsp_data.gesture);
            check_field("clear_status", oldest_result.clear_status, rsp_data.clear_status);
            check_field("touching", oldest_result.touching, rsp_data.touching);
            check_field("pos_x", oldest_result.pos_x, rsp_data.pos_x);
            check_field("pos_y", oldest_result.pos_y, rsp_data.pos_y);
         end
      end
   end

   // Watchdog: end the run if no channel moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int dw_pick, dh_pick;

      // Register and tracker state as after reset
      cfg_enable   = 1'b0;
      cfg_sens_x   = 16'd720;
      cfg_sens_y   = 16'd720;
      cfg_disp_w   = 12'd720;
      cfg_disp_h   = 12'd720;
      cfg_swipe_dy = 12'd80;
      cfg_swipe_dx = 12'd60;
      cfg_tap_move = 12'd20;
      was_down     = 1'b0;
      down_x       = '0;
      down_y       = '0;
      cur_x        = '0;
      cur_y        = '0;
      gap_frames   = '0;
      hold_off     = '0;
      err_run      = '0;
      contact      = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset setting (no scaling: sensor equals display)
      dir_rows.push_back(typed_row(mk_poll(1'b1, 8'h81, 1'b1, 16'd100, 16'd100),
                                   RSP_QUIET));           // disabled after reset
      dir_rows.push_back(csr_row(CSR_ENABLE, 16'd1));
      dir_rows.push_back(typed_row(mk_poll(1'b0, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF),
                                   RSP_QUIET));           // failed status read
      dir_rows.push_back(typed_row(mk_poll(1'b1, 8'h7F, 1'b1, 16'd0, 16'd0),
                                   RSP_QUIET));           // buffer not ready
      dir_rows.push_back(typed_row(mk_poll(1'b1, 8'h80, 1'b0, 16'd0, 16'd0),
                                   RSP_CLEARED));         // empty frame, no touch
      repeat (6) begin
         dir_rows.push_back(typed_row(mk_poll(1'b0, 8'h00, 1'b0, 16'd0, 16'd0),
                                      RSP_QUIET));        // push past the error limit
      end
      dir_rows.push_back(typed_row(mk_poll(1'b1, 8'h81, 1'b1, 16'd200, 16'd200),
                                   RSP_QUIET));           // served by the back-off
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h81, 1'b1, 16'd100, 16'd100)));
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h8F, 1'b1, 16'd110, 16'd300)));
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h85, 1'b0, 16'd9999, 16'd9999)));
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h80, 1'b1, 16'd0, 16'd0)));
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h80, 1'b1, 16'd0, 16'd0)));  // swipe down
      repeat (4) begin
         dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h81, 1'b1, 16'd500, 16'd500)));
      end
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'hF1, 1'b1, 16'hFFFF, 16'h0000)));
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h80, 1'b0, 16'd0, 16'd0)));
      dir_rows.push_back(poll_row(mk_poll(1'b1, 8'h80, 1'b0, 16'd0, 16'd0)));  // tap right

      // Walk the table; drain before a run of register writes, drop valid after it
      for (int i = 0; i < dir_rows.size(); i++) begin
         case (dir_rows[i].kind)
            ROW_CSR: begin
               if (i == 0 || dir_rows[i-1].kind != ROW_CSR) drain_block();
               write_reg(dir_rows[i].idx, dir_rows[i].word);
               if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CSR) begin
                  csr_valid <= 1'b0;
               end
            end
            default: begin
               send_poll(dir_rows[i].poll, dir_rows[i].typed, dir_rows[i].want);
            end
         endcase
      end
      settings_applied++;

      // Sender idles lightly, receiver heavily
      run_phase(cfg_set(16'd1, 16'd1440, 16'd2560, 16'd720, 16'd1280,
                        16'd80, 16'd60, 16'd20), 90);
      run_phase(cfg_set(16'd1, 16'd0, 16'd0, 16'd4095, 16'd4095,
                        16'd4095, 16'd4095, 16'd4095), 80);

      // Swap the idling: sender heavily, receiver lightly
      send_idle_pct = 70;
      recv_idle_pct = 21;
      run_phase(cfg_set(16'hFFFF, 16'd720, 16'd720, 16'hF000, 16'hF000,
                        16'd0, 16'd0, 16'd0), 40);        // zero display acts as one
      run_phase(cfg_set(16'hFFFE, 16'($urandom), 16'($urandom),
                        junk12($urandom_range(4095, 1)), junk12($urandom_range(4095, 1)),
                        junk12($urandom), junk12($urandom), junk12($urandom)), 30);
      run_phase(cfg_set(16'd1, 16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                        junk12($urandom_range(4095, 1)), junk12($urandom_range(4095, 1)),
                        junk12($urandom_range(300)), junk12($urandom_range(120)),
                        junk12($urandom_range(60))), 100);

      // No idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      dw_pick = $urandom_range(4095, 1);
      dh_pick = $urandom_range(4095, 1);
      run_phase(cfg_set(16'd1, 16'(dw_pick), 16'(dh_pick), 16'(dw_pick), 16'(dh_pick),
                        16'($urandom_range(200)), 16'($urandom_range(150)),
                        16'($urandom_range(80))), 100);   // sensor matches display
      run_phase(cfg_set(16'd1, 16'd65535, 16'd65535, 16'd4095, 16'd4095,
                        16'($urandom_range(400)), 16'($urandom_range(400)),
                        16'($urandom_range(100))), 80);

      drain_block();
      if (pending_results.size() != 0) begin
         fail_count++;
         $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      end

      $display("covered %0d polls under %0d register settings, %0d results checked",
               polls_sent, settings_applied, results_checked);
      $display("gestures seen: none %0d, up %0d, down %0d, left %0d, centre %0d, right %0d",
               gesture_seen[GEST_NONE], gesture_seen[GEST_SWIPE_UP],
               gesture_seen[GEST_SWIPE_DOWN], gesture_seen[GEST_TAP_LEFT],
               gesture_seen[GEST_TAP_CENTRE], gesture_seen[GEST_TAP_RIGHT]);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/tgc_pkg.sv
sv/tgc_divider.sv
sv/tgc_datapath.sv
sv/tgc_controller.sv
sv/touch_gesture_classifier.sv
sv/tgc_checker.sv
dv/touch_gesture_classifier_tb.sv
